FILE: rtl/pbba_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the paged bitmap block allocator.
// No dependencies; the RTL files that use it refer to it by scoped names, the testbench imports it.
package pbba_pkg;

    localparam int PAGES  = 64;
    localparam int PAGE_W = $clog2(PAGES);
    localparam int SLOT_W = 3;
    localparam int MASK_W = 8;
    localparam int CFG_W  = 7;

    localparam logic [CFG_W-1:0]  PAGES_LIMIT = CFG_W'(PAGES);
    localparam logic [CFG_W-1:0]  FS_PAGES_RST = 7'd64;
    localparam logic [MASK_W-1:0] ROOT_MASK  = 8'h80;
    localparam logic [MASK_W-1:0] FULL_MASK  = 8'hff;
    localparam logic [MASK_W-1:0] EMPTY_MASK = 8'h00;
    localparam logic [SLOT_W-1:0] SLOT_MAX   = 3'd7;

    localparam logic MODE_ALLOC  = 1'b0;
    localparam logic MODE_FREE   = 1'b1;
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_MODIFY
    } state_t;

    // Full-flag update sent from the read-modify-write stage to the free map
    typedef struct packed {
        logic              en;
        logic [PAGE_W-1:0] page;
        logic              full;
    } flag_upd_t;

    // Count the run of set bits from the low end of a mask that is not full
    function automatic logic [SLOT_W-1:0] low_run(input logic [MASK_W-1:0] mask);
        logic [SLOT_W-1:0] cnt;
        logic              run;
        cnt = '0;
        run = 1'b1;
        for (int i = 0; i < MASK_W - 1; i++) begin
            if (run && mask[i]) begin
                cnt = cnt + 1'b1;
            end
            else begin
                run = 1'b0;
            end
        end
        return cnt;
    endfunction

endpackage

FILE: rtl/pbba_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module pbba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/pbba_free_map.sv
`timescale 1ns / 1ps
// Full-page flag vector and priority search for the first usable page with room.
// Depends on pbba_pkg.
module pbba_free_map (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [pbba_pkg::CFG_W-1:0]   limit,
    input  pbba_pkg::flag_upd_t          upd,
    output logic                         found,
    output logic [pbba_pkg::PAGE_W-1:0]  page
);

    logic [pbba_pkg::PAGES-1:0] full_reg;
    logic [pbba_pkg::PAGES-1:0] full_next;
    logic [pbba_pkg::PAGES-1:0] open_vec;

    // Track which pages are full; every page starts with room
    always_comb
    begin
        full_next = full_reg;
        if (upd.en) begin
            full_next[upd.page] = upd.full;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            full_reg <= '0;
        end
        else begin
            full_reg <= full_next;
        end
    end

    // Mark pages below the limit that still have a free slot
    always_comb
    begin
        for (int i = 0; i < pbba_pkg::PAGES; i++) begin
            open_vec[i] = !full_reg[i] && (pbba_pkg::CFG_W'(i) < limit);
        end
    end

    // Pick the lowest open page
    always_comb
    begin
        found = 1'b0;
        page  = '0;
        for (int i = pbba_pkg::PAGES - 1; i >= 0; i--) begin
            if (open_vec[i]) begin
                found = 1'b1;
                page  = pbba_pkg::PAGE_W'(i);
            end
        end
    end

endmodule

FILE: rtl/paged_bitmap_block_allocator.sv
`timescale 1ns / 1ps
// Allocate or in-range free: mask read on accept, read-modify-write and result load in ST_MODIFY;
// failed allocate and out-of-range free load the result register on accept.
// A request that needs the mask RAM read-modify-write stalls the next one until ST_IDLE;
// failed allocates and out-of-range frees can follow one per cycle while out_stall is low.
// Reset: page 0 reads 0x80 and others 0 through per-page valid bits, no clearing pass;
// fs_pages resets to 64. Depends on pbba_pkg, pbba_ram and pbba_free_map.
module paged_bitmap_block_allocator (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pbba_pkg::CFG_W-1:0]        fs_pages,
    // Request channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              mode,
    input  logic [pbba_pkg::PAGE_W-1:0]       page_index,
    input  logic [pbba_pkg::SLOT_W-1:0]       slot_index,
    // Result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              status,
    output logic [pbba_pkg::PAGE_W-1:0]       block_page,
    output logic [pbba_pkg::SLOT_W-1:0]       block_slot
);

    pbba_pkg::state_t               state_reg, state_next;
    logic [pbba_pkg::CFG_W-1:0]     fs_pages_reg;
    logic [pbba_pkg::CFG_W-1:0]     limit;
    logic [pbba_pkg::PAGES-1:0]     valid_reg, valid_next;

    logic                           op_mode_reg;
    logic [pbba_pkg::PAGE_W-1:0]    op_page_reg;
    logic [pbba_pkg::SLOT_W-1:0]    op_slot_reg;

    logic                           out_valid_reg, out_valid_next;
    logic                           status_reg, status_next;
    logic [pbba_pkg::PAGE_W-1:0]    block_page_reg, block_page_next;
    logic [pbba_pkg::SLOT_W-1:0]    block_slot_reg, block_slot_next;

    logic                           accept;
    logic                           direct;
    logic                           load_out;
    logic                           found;
    logic [pbba_pkg::PAGE_W-1:0]    found_page;
    logic                           rd_en;
    logic [pbba_pkg::PAGE_W-1:0]    rd_addr;
    logic [pbba_pkg::MASK_W-1:0]    rd_data;
    logic [pbba_pkg::MASK_W-1:0]    mask_cur;
    logic [pbba_pkg::MASK_W-1:0]    mask_new;
    logic [pbba_pkg::SLOT_W-1:0]    run_len;
    logic [pbba_pkg::SLOT_W-1:0]    mod_slot;
    logic                           wr_en;
    pbba_pkg::flag_upd_t            upd;

    // Configuration register; the user must write it only while idle, the block does not enforce this
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fs_pages_reg <= pbba_pkg::FS_PAGES_RST;
        end
        else if (cfg_valid && cfg_ready) begin
            fs_pages_reg <= fs_pages;
        end
    end

    assign limit = (fs_pages_reg > pbba_pkg::PAGES_LIMIT) ? pbba_pkg::PAGES_LIMIT
                                                          : fs_pages_reg;

    // Page search over the full-flag vector
    pbba_free_map u_free_map (
        .clk   (clk),
        .rst_n (rst_n),
        .limit (limit),
        .upd   (upd),
        .found (found),
        .page  (found_page)
    );

    // Accept only in idle and when the output slot will be empty
    assign in_stall = !((state_reg == pbba_pkg::ST_IDLE) && (!out_valid_reg || !out_stall));
    assign accept   = in_valid && !in_stall;

    // Requests that finish without touching the mask memory
    always_comb
    begin
        if (mode == pbba_pkg::MODE_FREE) begin
            direct = {1'b0, page_index} >= limit;
        end
        else begin
            direct = !found;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pbba_pkg::ST_IDLE:
            begin
                if (accept && !direct) begin
                    state_next = pbba_pkg::ST_MODIFY;
                end
            end
            pbba_pkg::ST_MODIFY:
            begin
                state_next = pbba_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = pbba_pkg::ST_IDLE;
            end
        endcase
    end

    // Memory control outputs per state
    always_comb
    begin
        rd_en = 1'b0;
        wr_en = 1'b0;
        unique case (state_reg)
            pbba_pkg::ST_IDLE:
            begin
                rd_en = accept && !direct;
            end
            pbba_pkg::ST_MODIFY:
            begin
                wr_en = 1'b1;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    assign rd_addr = (mode == pbba_pkg::MODE_FREE) ? page_index : found_page;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= pbba_pkg::ST_IDLE;
        end
        else begin
            state_reg <= state_next;
        end
    end

    // Hold the item being worked on
    always_ff @(posedge clk)
    begin
        if (accept) begin
            op_mode_reg <= mode;
            op_page_reg <= rd_addr;
            op_slot_reg <= slot_index;
        end
    end

    pbba_ram #(
        .WIDTH (pbba_pkg::MASK_W),
        .DEPTH (pbba_pkg::PAGES)
    ) u_mask_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (op_page_reg),
        .wdata (mask_new),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Substitute the reset value for pages never written
    always_comb
    begin
        if (valid_reg[op_page_reg]) begin
            mask_cur = rd_data;
        end
        else if (op_page_reg == '0) begin
            mask_cur = pbba_pkg::ROOT_MASK;
        end
        else begin
            mask_cur = pbba_pkg::EMPTY_MASK;
        end
    end

    // Modify: set the first clear bit on allocate, toggle the slot bit on free
    assign run_len = pbba_pkg::low_run(mask_cur);

    always_comb
    begin
        if (op_mode_reg == pbba_pkg::MODE_FREE) begin
            mod_slot = op_slot_reg;
            mask_new = mask_cur ^ (pbba_pkg::ROOT_MASK >> op_slot_reg);
        end
        else begin
            mod_slot = pbba_pkg::SLOT_MAX - run_len;
            mask_new = mask_cur | (pbba_pkg::MASK_W'(1) << run_len);
        end
    end

    assign upd.en   = wr_en;
    assign upd.page = op_page_reg;
    assign upd.full = (mask_new == pbba_pkg::FULL_MASK);

    // Mark pages as written
    always_comb
    begin
        valid_next = valid_reg;
        if (wr_en) begin
            valid_next[op_page_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
        end
        else begin
            valid_reg <= valid_next;
        end
    end

    // Result register: load from a direct finish or from the modify step
    assign load_out = (accept && direct) || wr_en;

    always_comb
    begin
        out_valid_next  = load_out || (out_valid_reg && out_stall);
        status_next     = status_reg;
        block_page_next = block_page_reg;
        block_slot_next = block_slot_reg;
        priority if (wr_en) begin
            status_next     = pbba_pkg::STATUS_OK;
            block_page_next = op_page_reg;
            block_slot_next = mod_slot;
        end
        else if (accept && direct) begin
            status_next = pbba_pkg::STATUS_FAIL;
            if (mode == pbba_pkg::MODE_FREE) begin
                block_page_next = page_index;
                block_slot_next = slot_index;
            end
            else begin
                block_page_next = '0;
                block_slot_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg     <= status_next;
        block_page_reg <= block_page_next;
        block_slot_reg <= block_slot_next;
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign block_page = block_page_reg;
    assign block_slot = block_slot_reg;

endmodule

FILE: tb/sv/paged_bitmap_block_allocator_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for paged_bitmap_block_allocator: allocate and free items
// over the valid/stall channels, results predicted from a shadow copy of the page masks.
// Depends on pbba_pkg and the allocator RTL.
module paged_bitmap_block_allocator_tb;
    import pbba_pkg::*;

    localparam int MAX_CYCLES   = 200000;
    localparam int SEG_ITEMS    = 100;
    localparam int SEGS_PER_RUN = 5;
    localparam int QUEUE_DEPTH  = 4;

    typedef struct packed {
        logic              mode;
        logic [PAGE_W-1:0] page;
        logic [SLOT_W-1:0] slot;
    } block_req_t;

    typedef struct packed {
        logic              status;
        logic [PAGE_W-1:0] page;
        logic [SLOT_W-1:0] slot;
    } block_result_t;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              cfg_valid  = 1'b0;
    logic              cfg_ready;
    logic [CFG_W-1:0]  fs_pages   = FS_PAGES_RST;
    logic              in_valid   = 1'b0;
    logic              in_stall;
    logic              mode       = MODE_ALLOC;
    logic [PAGE_W-1:0] page_index = '0;
    logic [SLOT_W-1:0] slot_index = '0;
    logic              out_valid;
    logic              out_stall  = 1'b0;
    logic              status;
    logic [PAGE_W-1:0] block_page;
    logic [SLOT_W-1:0] block_slot;

    // Shadow of the block state
    logic [MASK_W-1:0] shadow_masks [PAGES];
    logic [CFG_W-1:0]  shadow_fs_pages;

    block_req_t    request_queue [$];
    block_result_t expected_results [$];
    int            mismatches    = 0;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    int            cycle_count   = 0;

    paged_bitmap_block_allocator u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .fs_pages   (fs_pages),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .page_index (page_index),
        .slot_index (slot_index),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .block_page (block_page),
        .block_slot (block_slot)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Pages reachable under the current fs_pages setting
    function automatic int usable_pages();
        int lim;
        lim = int'(shadow_fs_pages);
        if (lim > PAGES)
            lim = PAGES;
        if (lim > 64)
            lim = 64;
        return lim;
    endfunction

    // Apply one request to the shadow masks and return the block's answer
    function automatic block_result_t apply_request(block_req_t req);
        block_result_t     res;
        int                lim;
        logic [MASK_W-1:0] m;
        logic [SLOT_W-1:0] s;
        lim = usable_pages();
        if (req.mode == MODE_FREE)
        begin
            res.page = req.page;
            res.slot = req.slot;
            if (int'(req.page) >= lim)
                res.status = STATUS_FAIL;
            else
            begin
                shadow_masks[req.page] = shadow_masks[req.page] ^ (ROOT_MASK >> req.slot);
                res.status = STATUS_OK;
            end
            return res;
        end
        // First page that is not full; slot sits just above the low run of taken bits
        for (int i = 0; i < lim; i++)
        begin
            m = shadow_masks[i];
            if (m != FULL_MASK)
            begin
                s = SLOT_MAX;
                while (m[0] && s != 0)
                begin
                    m = m >> 1;
                    s = s - 1'b1;
                end
                shadow_masks[i] = shadow_masks[i] | (ROOT_MASK >> s);
                res.status = STATUS_OK;
                res.page   = PAGE_W'(i);
                res.slot   = s;
                return res;
            end
        end
        res.status = STATUS_FAIL;
        res.page   = '0;
        res.slot   = '0;
        return res;
    endfunction

    // Request driver: predict on accept, hold while stalled, idle at random
    always @(posedge clk)
    begin
        block_req_t next_req;
        if (in_valid && !in_stall)
            expected_results.push_back(apply_request({mode, page_index, slot_index}));
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || !in_stall)
        begin
            if (request_queue.size() != 0 && $urandom_range(99, 0) >= send_idle_pct)
            begin
                next_req   = request_queue.pop_front();
                in_valid   <= 1'b1;
                mode       <= next_req.mode;
                page_index <= next_req.page;
                slot_index <= next_req.slot;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result monitor: stall at random, check each accepted item against the oldest one due
    always @(posedge clk)
    begin
        block_result_t exp_res;
        out_stall <= rst_n && ($urandom_range(99, 0) < recv_idle_pct);
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result: status=%0d page=%0d slot=%0d",
                         $time, status, block_page, block_slot);
                mismatches++;
            end
            else
            begin
                exp_res = expected_results.pop_front();
                if (status !== exp_res.status)
                begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, exp_res.status, status);
                    mismatches++;
                end
                if (block_page !== exp_res.page)
                begin
                    $display("%0t: block_page mismatch: expected %0d, actual %0d",
                             $time, exp_res.page, block_page);
                    mismatches++;
                end
                if (block_slot !== exp_res.slot)
                begin
                    $display("%0t: block_slot mismatch: expected %0d, actual %0d",
                             $time, exp_res.slot, block_slot);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic queue_item(logic m, int p, int s);
        request_queue.push_back({m, PAGE_W'(p), SLOT_W'(s)});
    endtask

    // Wait until the block has returned every result owed
    task automatic drain();
        do
            @(negedge clk);
        while (request_queue.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_fs_pages(int value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        fs_pages  <= CFG_W'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        shadow_fs_pages = CFG_W'(value);
        @(negedge clk);
    endtask

    // Random mix of allocates and frees; most frees target a taken slot
    task automatic run_segment(int n_items);
        int alloc_pct;
        int lim;
        int p;
        int s;
        alloc_pct = $urandom_range(75, 30);
        for (int k = 0; k < n_items; k++)
        begin
            while (request_queue.size() >= QUEUE_DEPTH)
                @(negedge clk);
            lim = usable_pages();
            p = $urandom_range(PAGES - 1, 0);
            s = $urandom_range(7, 0);
            if ($urandom_range(99, 0) < alloc_pct)
                queue_item(MODE_ALLOC, p, s);
            else
            begin
                if (lim > 0 && $urandom_range(99, 0) < 75)
                begin
                    p = $urandom_range(lim - 1, 0);
                    if (shadow_masks[p] != EMPTY_MASK)
                        while (!shadow_masks[p][MASK_W - 1 - s])
                            s = $urandom_range(7, 0);
                end
                queue_item(MODE_FREE, p, s);
            end
        end
    endtask

    initial
    begin
        int fs_value;
        for (int p = 0; p < PAGES; p++)
            shadow_masks[p] = EMPTY_MASK;
        shadow_masks[0] = ROOT_MASK;
        shadow_fs_pages = FS_PAGES_RST;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Fill page 0 from the top slot down, spill into page 1
        repeat (7) queue_item(MODE_ALLOC, 0, 0);
        queue_item(MODE_ALLOC, 63, 7);
        // Freed hole in the middle of a run, then the root slot itself
        queue_item(MODE_FREE, 0, 3);
        queue_item(MODE_ALLOC, 0, 0);
        queue_item(MODE_FREE, 0, 0);
        queue_item(MODE_ALLOC, 0, 0);
        // Free of a free slot marks it taken, second free clears it
        queue_item(MODE_FREE, 5, 2);
        queue_item(MODE_FREE, 5, 2);
        queue_item(MODE_FREE, 63, 7);
        queue_item(MODE_FREE, 63, 0);
        drain();

        // Single page: full allocator and out-of-range free
        write_fs_pages(1);
        queue_item(MODE_ALLOC, 0, 0);
        queue_item(MODE_FREE, 1, 4);
        queue_item(MODE_FREE, 0, 7);
        queue_item(MODE_ALLOC, 0, 0);
        drain();

        // No usable page at all
        write_fs_pages(0);
        queue_item(MODE_ALLOC, 0, 0);
        queue_item(MODE_FREE, 0, 0);
        drain();

        // Setting above the page count clips to 64
        write_fs_pages(127);
        queue_item(MODE_FREE, 63, 5);
        queue_item(MODE_ALLOC, 0, 0);
        drain();

        // Random phases: receiver-heavy idling, sender-heavy idling, then none
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 36 : (ph == 1) ? 55 : 0;
            recv_idle_pct = (ph == 0) ? 55 : (ph == 1) ? 36 : 0;
            for (int seg = 0; seg < SEGS_PER_RUN; seg++)
            begin
                if (seg == 0)
                    fs_value = $urandom_range(4, 1);
                else
                begin
                    case ($urandom_range(6, 0))
                        0:       fs_value = 0;
                        1:       fs_value = 1;
                        2:       fs_value = 64;
                        3:       fs_value = 127;
                        4:       fs_value = $urandom_range(8, 2);
                        default: fs_value = $urandom_range(127, 0);
                    endcase
                end
                write_fs_pages(fs_value);
                run_segment(SEG_ITEMS);
                drain();
            end
        end

        repeat (20) @(negedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: files.f
rtl/pbba_pkg.sv
rtl/pbba_ram.sv
rtl/pbba_free_map.sv
rtl/paged_bitmap_block_allocator.sv
tb/sv/paged_bitmap_block_allocator_tb.sv
